### sv/sdx_pkg.sv
package sdx_pkg;

  typedef logic [2:0] code_t;

  localparam int unsigned NUM_OUT_DIGITS = 3;
  localparam logic [7:0] ASCII_A = 8'h41;
  localparam logic [7:0] ASCII_Z = 8'h5a;
  localparam code_t CODE_NONE = 3'd0;

  // letter index 0..25 -> soundex digit, 0 for vowels and H W Y
  function automatic code_t letter_digit(input logic [4:0] idx);
    code_t d;
    unique case (idx)
      5'd1, 5'd5, 5'd15, 5'd21:                         d = 3'd1;
      5'd2, 5'd6, 5'd9, 5'd10, 5'd16, 5'd18, 5'd23, 5'd25: d = 3'd2;
      5'd3, 5'd19:                                      d = 3'd3;
      5'd11:                                            d = 3'd4;
      5'd12, 5'd13:                                     d = 3'd5;
      5'd17:                                            d = 3'd6;
      default:                                          d = CODE_NONE;
    endcase
    return d;
  endfunction

endpackage

### sv/soundex_code_stream.sv
// Soundex code stream: one byte of a word per input word, last_of_word on the
// final byte. A new byte is taken every cycle unless the input stalls; when a
// word's last byte leaves the input register, its code is written into the
// output register and holds until taken, while following bytes keep flowing
// in. Only a word's last byte waits in the input register while the previous
// code is still untaken, and that stalls the input. Per byte the work is one
// letter lookup and one run-collapse update of the word state.
// Bytes outside 'A'..'Z' are skipped; a word without letters gives
// empty_word = 1 and a zero code. CODE_DIGITS digits are kept; digit fields
// beyond CODE_DIGITS read 0.
module soundex_code_stream
  import sdx_pkg::*;
#(
  parameter int unsigned CODE_DIGITS = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_last_of_word,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_lead_letter,
  output logic [2:0] out_digit_one,
  output logic [2:0] out_digit_two,
  output logic [2:0] out_digit_three,
  output logic       out_empty_word
);

  localparam int unsigned CNT_W = $clog2(CODE_DIGITS + 1);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;

  // word state
  logic [7:0]       held_lead_r,     held_lead_nxt;
  logic             lead_seen_r,     lead_seen_nxt;
  code_t            previous_code_r, previous_code_nxt;
  logic [CNT_W-1:0] digits_taken_r,  digits_taken_nxt;
  code_t            store_r   [CODE_DIGITS];
  code_t            store_nxt [CODE_DIGITS];

  // result register
  logic       out_valid_r;
  logic [7:0] out_lead_r;
  code_t      out_d1_r, out_d2_r, out_d3_r;
  logic       out_empty_r;

  logic       out_free;
  logic       s1_adv;
  logic       is_letter;
  code_t      code;
  logic       coded;
  logic       store_en;
  code_t [NUM_OUT_DIGITS-1:0] res_digits;

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready = !s1_valid_r || s1_adv;

  assign is_letter = (s1_char_r >= ASCII_A) && (s1_char_r <= ASCII_Z);
  assign code      = letter_digit(5'(s1_char_r - ASCII_A));
  assign coded     = is_letter && lead_seen_r && (code != CODE_NONE);
  assign store_en  = coded && (code != previous_code_r) &&
                     (digits_taken_r < CNT_W'(CODE_DIGITS));

  always_comb begin
    held_lead_nxt     = held_lead_r;
    lead_seen_nxt     = lead_seen_r;
    previous_code_nxt = coded ? code : previous_code_r;
    digits_taken_nxt  = store_en ? digits_taken_r + CNT_W'(1) : digits_taken_r;
    if (is_letter && !lead_seen_r) begin
      held_lead_nxt = s1_char_r;
      lead_seen_nxt = 1'b1;
    end
    for (int i = 0; i < CODE_DIGITS; i++) begin
      store_nxt[i] = (store_en && digits_taken_r == CNT_W'(i)) ? code : store_r[i];
    end
  end

  for (genvar k = 0; k < NUM_OUT_DIGITS; k++) begin : g_res
    if (k < CODE_DIGITS) begin : g_kept
      assign res_digits[k] = store_nxt[k];
    end else begin : g_pad
      assign res_digits[k] = CODE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      held_lead_r     <= '0;
      lead_seen_r     <= 1'b0;
      previous_code_r <= CODE_NONE;
      digits_taken_r  <= '0;
      for (int i = 0; i < CODE_DIGITS; i++) store_r[i] <= CODE_NONE;
      out_valid_r     <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        if (s1_last_r) begin
          held_lead_r     <= '0;
          lead_seen_r     <= 1'b0;
          previous_code_r <= CODE_NONE;
          digits_taken_r  <= '0;
          for (int i = 0; i < CODE_DIGITS; i++) store_r[i] <= CODE_NONE;
        end else begin
          held_lead_r     <= held_lead_nxt;
          lead_seen_r     <= lead_seen_nxt;
          previous_code_r <= previous_code_nxt;
          digits_taken_r  <= digits_taken_nxt;
          store_r         <= store_nxt;
        end
      end
      if (s1_adv && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_char_r <= in_char_code;
      s1_last_r <= in_last_of_word;
    end
    if (s1_adv && s1_last_r) begin
      out_lead_r  <= lead_seen_nxt ? held_lead_nxt : 8'd0;
      out_d1_r    <= lead_seen_nxt ? res_digits[0] : CODE_NONE;
      out_d2_r    <= lead_seen_nxt ? res_digits[1] : CODE_NONE;
      out_d3_r    <= lead_seen_nxt ? res_digits[2] : CODE_NONE;
      out_empty_r <= !lead_seen_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_lead_letter = out_lead_r;
  assign out_digit_one   = out_d1_r;
  assign out_digit_two   = out_d2_r;
  assign out_digit_three = out_d3_r;
  assign out_empty_word  = out_empty_r;

  a_clear_after_word: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> !lead_seen_r && digits_taken_r == '0)
    else $error("word state not cleared after last byte");

  a_taken_bound: assert property (@(posedge clk) disable iff (!rst_n)
    digits_taken_r <= CNT_W'(CODE_DIGITS))
    else $error("digit count past CODE_DIGITS");

  a_prev_implies_digit: assert property (@(posedge clk) disable iff (!rst_n)
    previous_code_r != CODE_NONE |-> digits_taken_r != '0 && lead_seen_r)
    else $error("previous code without stored digit");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_empty_r |-> out_lead_r == 8'd0 && out_d1_r == CODE_NONE &&
      out_d2_r == CODE_NONE && out_d3_r == CODE_NONE)
    else $error("empty word with nonzero code");

endmodule

### tb/tb_top.sv
module tb_top;
  import sdx_pkg::*;

  localparam int unsigned KEPT_DIGITS = 3;
  localparam int STREAM_BYTES = 1550;

  typedef struct packed {
    logic [7:0] lead_letter;
    logic [2:0] digit_one;
    logic [2:0] digit_two;
    logic [2:0] digit_three;
    logic       empty_word;
  } soundex_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         typed;
    soundex_t   code;
  } char_row_t;

  localparam soundex_t EMPTY_CODE = '{8'h00, 3'd0, 3'd0, 3'd0, 1'b1};
  localparam logic [2:0] DIGIT_OF [0:25] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd0, 3'd0, 3'd2, 3'd2, 3'd4, 3'd5,
    3'd5, 3'd0, 3'd1, 3'd2, 3'd6, 3'd2, 3'd3, 3'd0, 3'd1, 3'd0, 3'd2, 3'd0, 3'd2
  };
  localparam logic [7:0] SILENT_LETTERS [0:7] = '{"A", "E", "I", "O", "U", "Y", "H", "W"};

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_char_code;
  logic       in_last_of_word;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_lead_letter;
  logic [2:0] out_digit_one;
  logic [2:0] out_digit_two;
  logic [2:0] out_digit_three;
  logic       out_empty_word;

  // word state of the predictor
  logic [7:0] held_lead;
  bit         lead_seen;
  logic [2:0] last_code;
  int         n_digits;
  logic [2:0] digits [NUM_OUT_DIGITS];

  soundex_t codes_due [$];
  soundex_t due;
  int       fail_count;
  int       bytes_taken;
  int       calm_in;
  int       calm_out;

  char_row_t directed_rows [0:24] = '{
    '{8'h00, 1'b1, 1'b1, EMPTY_CODE},
    '{8'hFF, 1'b1, 1'b1, EMPTY_CODE},
    '{"A", 1'b1, 1'b1, '{"A", 3'd0, 3'd0, 3'd0, 1'b0}},
    '{"Z", 1'b1, 1'b1, '{"Z", 3'd0, 3'd0, 3'd0, 1'b0}},
    '{"P", 1'b0, 1'b0, '0},
    '{"F", 1'b0, 1'b0, '0},
    '{"I", 1'b0, 1'b0, '0},
    '{"S", 1'b0, 1'b0, '0},
    '{"T", 1'b0, 1'b0, '0},
    '{"E", 1'b0, 1'b0, '0},
    '{"R", 1'b1, 1'b0, '0},
    '{"b", 1'b0, 1'b0, '0},
    '{"Z", 1'b0, 1'b0, '0},
    '{"@", 1'b0, 1'b0, '0},
    '{"L", 1'b0, 1'b0, '0},
    '{"[", 1'b1, 1'b0, '0},
    '{"S", 1'b0, 1'b0, '0},
    '{"B", 1'b0, 1'b0, '0},
    '{"W", 1'b0, 1'b0, '0},
    '{"B", 1'b0, 1'b0, '0},
    '{"D", 1'b0, 1'b0, '0},
    '{"D", 1'b1, 1'b0, '0},
    '{"M", 1'b0, 1'b0, '0},
    '{"M", 1'b0, 1'b0, '0},
    '{"N", 1'b1, 1'b0, '0}
  };

  soundex_code_stream #(
    .CODE_DIGITS(KEPT_DIGITS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_code   (in_char_code),
    .in_last_of_word(in_last_of_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_lead_letter(out_lead_letter),
    .out_digit_one  (out_digit_one),
    .out_digit_two  (out_digit_two),
    .out_digit_three(out_digit_three),
    .out_empty_word (out_empty_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic clear_word();
    held_lead = 8'h00;
    lead_seen = 1'b0;
    last_code = CODE_NONE;
    n_digits  = 0;
    foreach (digits[i]) digits[i] = CODE_NONE;
  endtask

  task automatic code_char(input logic [7:0] c, input logic l, output bit has,
                           output soundex_t code);
    logic [2:0] d;
    has  = 1'b0;
    code = '0;
    if (c >= ASCII_A && c <= ASCII_Z) begin
      if (!lead_seen) begin
        held_lead = c;
        lead_seen = 1'b1;
      end else begin
        d = DIGIT_OF[int'(c - ASCII_A)];
        if (d != CODE_NONE) begin
          if (d != last_code && n_digits < KEPT_DIGITS) begin
            digits[n_digits] = d;
            n_digits++;
          end
          last_code = d;
        end
      end
    end
    if (l) begin
      has = 1'b1;
      if (lead_seen) code = '{held_lead, digits[0], digits[1], digits[2], 1'b0};
      else code = EMPTY_CODE;
      clear_word();
    end
  endtask

  // mostly short gaps, a few long, and now and then a run with none
  task automatic pick_gap(inout int calm, output int gap);
    int r;
    gap = 0;
    if (calm > 0) begin
      calm--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) calm = $urandom_range(20, 80);
      else if (r < 50) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
    end
  endtask

  function automatic logic [7:0] noise_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c >= ASCII_A && c <= ASCII_Z);
    return c;
  endfunction

  function automatic logic [7:0] pick_letter(input logic [7:0] prev_c);
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return ASCII_A + 8'($urandom_range(0, 25));
    if (r < 80) return SILENT_LETTERS[$urandom_range(0, 7)];
    if (r < 93) return prev_c;
    if (r < 97) return 8'($urandom_range(0, 255));
    return noise_byte();
  endfunction

  task automatic send_char(input logic [7:0] c, input logic l, input bit typed,
                           input soundex_t typed_code);
    bit       has;
    soundex_t code;
    int       gap;
    in_char_code    <= c;
    in_last_of_word <= l;
    in_valid        <= 1'b1;
    do @(posedge clk); while (!in_ready);
    code_char(c, l, has, code);
    if (has) codes_due.push_back(typed ? typed_code : code);
    bytes_taken++;
    @(negedge clk);
    pick_gap(calm_in, gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $error("%s expected %0d got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (codes_due.size() == 0) begin
        $error("code word with none expected: lead_letter %0d", out_lead_letter);
        fail_count++;
      end else begin
        due = codes_due.pop_front();
        check_field("lead_letter", int'(due.lead_letter), int'(out_lead_letter));
        check_field("digit_one", int'(due.digit_one), int'(out_digit_one));
        check_field("digit_two", int'(due.digit_two), int'(out_digit_two));
        check_field("digit_three", int'(due.digit_three), int'(out_digit_three));
        check_field("empty_word", int'(due.empty_word), int'(out_empty_word));
      end
    end
  end

  initial begin
    int gap;
    int high_len;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_ready <= 1'b1;
      high_len = $urandom_range(1, 8);
      repeat (high_len) @(negedge clk);
      pick_gap(calm_out, gap);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  end

  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int         kind;
    int         len;
    logic [7:0] c;
    logic [7:0] prev_c;
    fail_count      = 0;
    bytes_taken     = 0;
    calm_in         = 0;
    calm_out        = 0;
    prev_c          = "A";
    clear_word();
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_char_code    <= 8'h00;
    in_last_of_word <= 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_char(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].code);

    while (bytes_taken < STREAM_BYTES + 25) begin
      kind = $urandom_range(0, 99);
      if (kind < 5) len = $urandom_range(1, 3);
      else if (kind < 10) len = 1;
      else len = $urandom_range(2, 12);
      for (int k = 0; k < len; k++) begin
        c = (kind < 5) ? noise_byte() : pick_letter(prev_c);
        if (c >= ASCII_A && c <= ASCII_Z) prev_c = c;
        send_char(c, k == len - 1, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    wait (codes_due.size() == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
